// ===== sv/fmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared types and constants for the metal surface Fresnel reflection core.
// ----------------------------------------------------------------------------
package fmr_pkg;

  // Fixed point formats
  localparam int DIR_FRAC_BITS   = 15;  // Q1.15 directions
  localparam int INDEX_FRAC_BITS = 12;  // Q4.12 index registers
  localparam int COS_FRAC_BITS   = 24;  // internal cosine format

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_INDEX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_INDEX = 2'd1;
  localparam logic [CFG_DATA_W-1:0] REAL_INDEX_RST = 16'd4096;
  localparam logic [CFG_DATA_W-1:0] IMAG_INDEX_RST = 16'd0;

  // Square root pipeline: radicand width and result bits per stage
  localparam int SQRT_IN_W   = 64;
  localparam int SQRT_STEPS  = 4;
  localparam int SQRT_STAGES = (SQRT_IN_W / 2) / SQRT_STEPS;

  // Ratio divider pipeline
  localparam int DIV_NUM_W  = 46;
  localparam int DIV_Q_W    = 17;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = (DIV_Q_W + DIV_STEPS - 1) / DIV_STEPS;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [15:0] random_draw;
  } in_t;

  typedef struct packed {
    logic               absorbed;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic        [15:0] reflectance;
  } out_t;

endpackage

// ===== sv/fmr_delay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_delay
// Enabled shift line that keeps sideband data level with a pipelined unit.
// ----------------------------------------------------------------------------
module fmr_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] data_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  assign data_o = line_q[DEPTH-1];

endmodule

// ===== sv/fmr_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_isqrt
// Pipelined integer square root (floor), digit by digit, STEPS result bits
// per register stage.
// ----------------------------------------------------------------------------
module fmr_isqrt #(
  parameter int IN_W  = fmr_pkg::SQRT_IN_W,
  parameter int STEPS = fmr_pkg::SQRT_STEPS
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [IN_W-1:0]   rad_i,
  output logic [IN_W/2-1:0] root_o
);

  localparam int OUT_W = IN_W / 2;
  localparam int NSTG  = OUT_W / STEPS;
  localparam int RW    = OUT_W + 3;

  logic [IN_W-1:0]  rad_q  [NSTG];
  logic [RW-1:0]    rem_q  [NSTG];
  logic [OUT_W-1:0] root_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [IN_W-1:0]  rad_in, rad_d;
    logic [RW-1:0]    rem_in, rem_d;
    logic [OUT_W-1:0] root_in, root_d;

    if (s == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    always_comb begin
      logic [RW-1:0] trial;
      rad_d  = rad_in;
      rem_d  = rem_in;
      root_d = root_in;
      trial  = '0;
      for (int t = 0; t < STEPS; t++) begin
        // bring down the next two radicand bits
        rem_d = {rem_d[RW-3:0], rad_d[IN_W-1 -: 2]};
        rad_d = rad_d << 2;
        trial = {1'b0, root_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[OUT_W-2:0], 1'b1};
        end else begin
          root_d = {root_d[OUT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= rad_d;
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
      end
    end
  end

  assign root_o = root_q[NSTG-1];

endmodule

// ===== sv/fmr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_div
// Pipelined restoring divider giving floor(num * 2^(Q_W-1) / den).
// Expects num < 2*den; the caller handles the other cases.
// ----------------------------------------------------------------------------
module fmr_div #(
  parameter int NUM_W = fmr_pkg::DIV_NUM_W,
  parameter int Q_W   = fmr_pkg::DIV_Q_W,
  parameter int STEPS = fmr_pkg::DIV_STEPS
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [NUM_W-1:0] den_i,
  output logic [Q_W-1:0]   quot_o
);

  localparam int NSTG = (Q_W + STEPS - 1) / STEPS;
  localparam int RW   = NUM_W + 1;

  logic [RW-1:0]    rem_q [NSTG];
  logic [NUM_W-1:0] den_q [NSTG];
  logic [Q_W-1:0]   quo_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [RW-1:0]    rem_in, rem_d;
    logic [NUM_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in, quo_d;

    if (s == 0) begin : g_first
      assign rem_in = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic q_bit;
      rem_d = rem_in;
      quo_d = quo_in;
      q_bit = 1'b0;
      for (int t = 0; t < STEPS; t++) begin
        if (s * STEPS + t < Q_W) begin
          q_bit = (rem_d >= {1'b0, den_in});
          if (q_bit) begin
            rem_d = rem_d - {1'b0, den_in};
          end
          // remainder stays below den here, so the shift cannot overflow
          rem_d = rem_d << 1;
          quo_d = {quo_d[Q_W-2:0], q_bit};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign quot_o = quo_q[NSTG-1];

endmodule

// ===== sv/fresnel_metal_reflect_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_metal_reflect_core
// Photon hit on a metal surface: unpolarised Fresnel reflectance from the
// incidence cosine and a complex index, then absorb or mirror the direction.
// ----------------------------------------------------------------------------
// Fully pipelined: one photon is accepted every clock cycle unless a held
// output beat stalls it; each result passes through 7 front stages, two 8-stage
// square root chains in series with one stage between, 5 ratio stages, a
// 6-stage divider and the output register. A stall on a valid output beat holds
// the whole pipeline; no beat is lost or repeated. There is no reset sweep. The
// user writes the index registers through the plain write port only while no
// photon is in flight, not enforced by the block; they apply to the next beat.
module fresnel_metal_reflect_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fmr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fmr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fmr_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fmr_pkg::out_t                   out_data_o
);

  localparam int SQ  = fmr_pkg::SQRT_STAGES;
  localparam int DV  = fmr_pkg::DIV_STAGES;
  localparam int LAT = 7 + SQ + 1 + SQ + 5 + DV + 1;

  localparam int COS_SHIFT  = 2 * fmr_pkg::DIR_FRAC_BITS - fmr_pkg::COS_FRAC_BITS;
  localparam int MIR_SHIFT  = 2 * fmr_pkg::DIR_FRAC_BITS;
  localparam int SIN_SHIFT  = 2 * fmr_pkg::COS_FRAC_BITS - 2 * fmr_pkg::INDEX_FRAC_BITS;
  localparam int ROOT_SHIFT = 2 * fmr_pkg::INDEX_FRAC_BITS;
  localparam int NORM_BITS  = 22;

  localparam logic signed [33:0] COS_ONE     = 34'sd16777216;
  localparam logic signed [33:0] COS_NEG_ONE = -34'sd16777216;
  localparam logic signed [25:0] COS_NEAR    = 26'sd16777215;
  localparam logic signed [51:0] SQ_ONE      = 52'sd1 <<< (2 * fmr_pkg::COS_FRAC_BITS);
  localparam logic signed [51:0] MIR_HALF    = 52'sd1 <<< (MIR_SHIFT - 1);
  localparam logic [17:0]        RATIO_CAP   = 18'd131072;

  typedef struct packed {
    logic signed [15:0] d_x;
    logic signed [15:0] d_y;
    logic signed [15:0] d_z;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic        [15:0] draw;
  } tail_t;

  typedef struct packed {
    logic signed [25:0] c;
    logic signed [35:0] pr;
    logic signed [35:0] pim;
    logic signed [31:0] xr;
    logic        [2:0]  e;
    tail_t              tail;
  } side_t;

  typedef struct packed {
    logic [1:0] cap;
    tail_t      tail;
  } fin_t;

  function automatic logic signed [15:0] sat16(input logic signed [22:0] x);
    logic signed [15:0] r;
    if (x > 23'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -23'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake: the whole pipe moves unless the output beat is held
  // --------------------------------------------------------------------------
  logic           adv;
  logic [LAT-1:0] vld_q;

  assign adv         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Configuration and N^2 (Q.24); the user keeps them static while photons are in flight, not enforced by the block
  // --------------------------------------------------------------------------
  logic [15:0] real_q, imag_q;
  logic [31:0] nn, kk, nk;
  logic signed [34:0] n2re_q, n2im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_q <= fmr_pkg::REAL_INDEX_RST;
      imag_q <= fmr_pkg::IMAG_INDEX_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fmr_pkg::CFG_REAL_INDEX: real_q <= cfg_data_i;
        fmr_pkg::CFG_IMAG_INDEX: imag_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nn = real_q * real_q;
  assign kk = imag_q * imag_q;
  assign nk = real_q * imag_q;

  always_ff @(posedge clk_i) begin
    n2re_q <= $signed({3'b000, nn}) - $signed({3'b000, kk});
    n2im_q <= $signed({2'b00, nk, 1'b0});
  end

  // --------------------------------------------------------------------------
  // Stage 1: component products of d.u
  // --------------------------------------------------------------------------
  logic signed [31:0] p1_q [3];
  fmr_pkg::in_t       in1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q[0] <= in_data_i.dir_x * in_data_i.normal_x;
      p1_q[1] <= in_data_i.dir_y * in_data_i.normal_y;
      p1_q[2] <= in_data_i.dir_z * in_data_i.normal_z;
      in1_q   <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: dot product, cosine in Q.24 clamped to +-1
  // --------------------------------------------------------------------------
  logic signed [33:0] sdot_d, cfl;
  logic signed [25:0] c_d;
  logic signed [33:0] sdot2_q;
  logic signed [25:0] c2_q;
  fmr_pkg::in_t       in2_q;

  always_comb begin
    sdot_d = 34'(p1_q[0]) + 34'(p1_q[1]) + 34'(p1_q[2]);
    cfl    = sdot_d >>> COS_SHIFT;
    if (cfl > COS_ONE) begin
      c_d = 26'(COS_ONE);
    end else if (cfl < COS_NEG_ONE) begin
      c_d = 26'(COS_NEG_ONE);
    end else begin
      c_d = 26'(cfl);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sdot2_q <= sdot_d;
      c2_q    <= c_d;
      in2_q   <= in1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: c^2 and the mirror products S*u
  // --------------------------------------------------------------------------
  logic signed [51:0] csq3_q;
  logic signed [49:0] mp3_q [3];
  logic signed [25:0] c3_q;
  fmr_pkg::in_t       in3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      csq3_q   <= c2_q * c2_q;
      mp3_q[0] <= sdot2_q * in2_q.normal_x;
      mp3_q[1] <= sdot2_q * in2_q.normal_y;
      mp3_q[2] <= sdot2_q * in2_q.normal_z;
      c3_q     <= c2_q;
      in3_q    <= in2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: N^2 - sin^2, N^2*c, mirrored direction
  // --------------------------------------------------------------------------
  logic signed [51:0] omc;
  logic signed [25:0] s2;
  logic signed [60:0] prm, pim_m;
  logic signed [51:0] mt [3];
  logic signed [22:0] mq [3];
  logic signed [15:0] dv [3];
  logic signed [15:0] res [3];

  logic signed [35:0] zr4_q, pr4_q, pim4_q;
  logic signed [25:0] c4_q;
  tail_t              tail4_q;

  always_comb begin
    omc = SQ_ONE - csq3_q;
    // near normal incidence sin^2 is taken as exactly zero
    s2  = (c3_q >= COS_NEAR) ? '0 : 26'(omc >>> SIN_SHIFT);
    prm   = n2re_q * c3_q;
    pim_m = n2im_q * c3_q;
    dv[0] = in3_q.dir_x;
    dv[1] = in3_q.dir_y;
    dv[2] = in3_q.dir_z;
    for (int i = 0; i < 3; i++) begin
      mt[i]  = (52'(mp3_q[i]) <<< 1) + MIR_HALF;
      mq[i]  = 23'(mt[i] >>> MIR_SHIFT);
      res[i] = sat16(23'(dv[i]) - mq[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zr4_q        <= 36'(n2re_q) - 36'(s2);
      pr4_q        <= 36'(prm >>> fmr_pkg::COS_FRAC_BITS);
      pim4_q       <= 36'(pim_m >>> fmr_pkg::COS_FRAC_BITS);
      c4_q         <= c3_q;
      tail4_q.d_x  <= in3_q.dir_x;
      tail4_q.d_y  <= in3_q.dir_y;
      tail4_q.d_z  <= in3_q.dir_z;
      tail4_q.r_x  <= res[0];
      tail4_q.r_y  <= res[1];
      tail4_q.r_z  <= res[2];
      tail4_q.draw <= in3_q.random_draw;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: even pre-shift so both parts of z sit below 2^31
  // --------------------------------------------------------------------------
  logic [35:0] zmag, zim, big;
  logic [2:0]  e_d;
  side_t       side5_q;
  logic [30:0] yi5_q;

  always_comb begin
    zmag = zr4_q[35] ? 36'(-zr4_q) : 36'(zr4_q);
    zim  = 36'(n2im_q);
    big  = (zim > zmag) ? zim : zmag;
    if (big[35:31] == '0) begin
      e_d = 3'd0;
    end else if (big[35:33] == '0) begin
      e_d = 3'd2;
    end else begin
      e_d = 3'd4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side5_q.c    <= c4_q;
      side5_q.pr   <= pr4_q;
      side5_q.pim  <= pim4_q;
      side5_q.xr   <= 32'(zr4_q >>> e_d);
      side5_q.e    <= e_d;
      side5_q.tail <= tail4_q;
      yi5_q        <= 31'(zim >> e_d);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 6-7: |z|^2
  // --------------------------------------------------------------------------
  logic [63:0] sqx6_q, sqy6_q, v7_q;
  side_t       side6_q, side7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx6_q  <= 64'(side5_q.xr * side5_q.xr);
      sqy6_q  <= 64'(yi5_q) * 64'(yi5_q);
      side6_q <= side5_q;
      v7_q    <= sqx6_q + sqy6_q;
      side7_q <= side6_q;
    end
  end

  // --------------------------------------------------------------------------
  // |z| then the two half sums, then Re and Im of the complex root
  // --------------------------------------------------------------------------
  logic [31:0] zabs;
  side_t       side_r;

  fmr_isqrt u_sqrt_abs (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (v7_q),
    .root_o (zabs)
  );

  fmr_delay #(.W($bits(side_t)), .DEPTH(SQ)) u_dly_abs (
    .clk_i  (clk_i),
    .en_i   (adv),
    .data_i (side7_q),
    .data_o (side_r)
  );

  logic signed [33:0] hp, hm;
  logic [4:0]         hsh;
  logic [63:0]        ra8_q, rb8_q;
  side_t              side8_q;

  // shift back by e + 2F; the shift never exceeds 28 at these formats
  always_comb begin
    hp  = $signed({2'b00, zabs}) + 34'(side_r.xr);
    hm  = $signed({2'b00, zabs}) - 34'(side_r.xr);
    hsh = 5'(side_r.e) + 5'(ROOT_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ra8_q   <= 64'(hp[32:1]) << hsh;
      rb8_q   <= 64'(hm[32:1]) << hsh;
      side8_q <= side_r;
    end
  end

  logic [31:0] root_a, root_b;
  side_t       side_a;

  fmr_isqrt u_sqrt_re (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (ra8_q),
    .root_o (root_a)
  );

  fmr_isqrt u_sqrt_im (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rb8_q),
    .root_o (root_b)
  );

  fmr_delay #(.W($bits(side_t)), .DEPTH(SQ)) u_dly_root (
    .clk_i  (clk_i),
    .en_i   (adv),
    .data_i (side8_q),
    .data_o (side_a)
  );

  // --------------------------------------------------------------------------
  // Stage 9: numerator and denominator parts of rs and rp
  // --------------------------------------------------------------------------
  logic signed [36:0] cw, a37, b37, pr37, pim37;
  logic signed [36:0] op9_q [2][4];
  tail_t              tail9_q;

  always_comb begin
    cw    = 37'(side_a.c);
    a37   = $signed({5'b00000, root_a});
    b37   = $signed({5'b00000, root_b});
    pr37  = 37'(side_a.pr);
    pim37 = 37'(side_a.pim);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op9_q[0][0] <= cw - a37;
      op9_q[0][1] <= -b37;
      op9_q[0][2] <= cw + a37;
      op9_q[0][3] <= b37;
      op9_q[1][0] <= a37 - pr37;
      op9_q[1][1] <= b37 - pim37;
      op9_q[1][2] <= a37 + pr37;
      op9_q[1][3] <= b37 + pim37;
      tail9_q     <= side_a.tail;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: largest magnitude of each ratio
  // --------------------------------------------------------------------------
  logic [35:0]        mag [2][4];
  logic [35:0]        mx_d [2];
  logic [35:0]        mx10_q [2];
  logic signed [36:0] op10_q [2][4];
  tail_t              tail10_q;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      mx_d[r] = '0;
      for (int i = 0; i < 4; i++) begin
        mag[r][i] = op9_q[r][i][36] ? 36'(-op9_q[r][i]) : 36'(op9_q[r][i]);
        if (mag[r][i] > mx_d[r]) begin
          mx_d[r] = mag[r][i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx10_q   <= mx_d;
      op10_q   <= op9_q;
      tail10_q <= tail9_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: floor shift, shared by the four parts of each ratio, to below 2^22
  // --------------------------------------------------------------------------
  logic [3:0]         nsh [2];
  logic signed [23:0] n11_q [2][4];
  tail_t              tail11_q;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      nsh[r] = '0;
      for (int b = NORM_BITS; b < 36; b++) begin
        if (mx10_q[r][b]) begin
          nsh[r] = 4'(b - NORM_BITS + 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 2; r++) begin
        for (int i = 0; i < 4; i++) begin
          n11_q[r][i] <= 24'(op10_q[r][i] >>> nsh[r]);
        end
      end
      tail11_q <= tail10_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 12-13: squared magnitudes, sums and the cap test
  // --------------------------------------------------------------------------
  logic [fmr_pkg::DIV_NUM_W-1:0] sq12_q [2][4];
  logic [fmr_pkg::DIV_NUM_W-1:0] num13_q [2], den13_q [2];
  logic [fmr_pkg::DIV_NUM_W-1:0] num_d [2], den_d [2];
  logic [1:0]                    cap_d, cap13_q;
  tail_t                         tail12_q, tail13_q;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      num_d[r] = sq12_q[r][0] + sq12_q[r][1];
      den_d[r] = sq12_q[r][2] + sq12_q[r][3];
      // zero denominator or ratio of two or more: hold at 2.0
      cap_d[r] = (den_d[r] == '0) || ({1'b0, num_d[r]} >= {den_d[r], 1'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 2; r++) begin
        for (int i = 0; i < 4; i++) begin
          sq12_q[r][i] <= fmr_pkg::DIV_NUM_W'(n11_q[r][i] * n11_q[r][i]);
        end
      end
      tail12_q <= tail11_q;
      num13_q  <= num_d;
      den13_q  <= den_d;
      cap13_q  <= cap_d;
      tail13_q <= tail12_q;
    end
  end

  // --------------------------------------------------------------------------
  // Ratio dividers
  // --------------------------------------------------------------------------
  logic [fmr_pkg::DIV_Q_W-1:0] q_rs, q_rp;
  fin_t                        fin13, fin_r;

  assign fin13.cap  = cap13_q;
  assign fin13.tail = tail13_q;

  fmr_div u_div_rs (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (num13_q[0]),
    .den_i  (den13_q[0]),
    .quot_o (q_rs)
  );

  fmr_div u_div_rp (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (num13_q[1]),
    .den_i  (den13_q[1]),
    .quot_o (q_rp)
  );

  fmr_delay #(.W($bits(fin_t)), .DEPTH(DV)) u_dly_div (
    .clk_i  (clk_i),
    .en_i   (adv),
    .data_i (fin13),
    .data_o (fin_r)
  );

  // --------------------------------------------------------------------------
  // Output stage: mean reflectance, absorb test, output register
  // --------------------------------------------------------------------------
  logic [17:0]   rs_v, rp_v;
  logic [18:0]   rsum;
  logic [15:0]   refl;
  logic          absorb;
  fmr_pkg::out_t out_d, out_q;

  always_comb begin
    rs_v   = fin_r.cap[0] ? RATIO_CAP : {1'b0, q_rs};
    rp_v   = fin_r.cap[1] ? RATIO_CAP : {1'b0, q_rp};
    rsum   = {1'b0, rs_v} + {1'b0, rp_v};
    refl   = (rsum[18:17] != 2'b00) ? 16'hffff : rsum[16:1];
    absorb = fin_r.tail.draw > refl;

    out_d.absorbed    = absorb;
    out_d.out_x       = absorb ? fin_r.tail.d_x : fin_r.tail.r_x;
    out_d.out_y       = absorb ? fin_r.tail.d_y : fin_r.tail.r_y;
    out_d.out_z       = absorb ? fin_r.tail.d_z : fin_r.tail.r_z;
    out_d.reflectance = refl;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  // input side is held exactly when a finished beat waits
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow the held output beat");

  // a draw above a saturated reflectance cannot exist
  a_absorb_refl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.absorbed) |-> (out_data_o.reflectance != 16'hffff))
    else $error("absorbed beat with full reflectance");

  // a held beat keeps the pipe frozen for the next cycle
  a_hold_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved while the output beat was held");
`endif

endmodule
